@@ src/drow_pkg.sv @@
// ----------------------------------------------------------------------------
// drow_pkg: shared types and constants for the dense rank block
// Holds the sizing constants, the payload structs, the state encodings and
// the command struct passed from the controller to the rank store.
// ----------------------------------------------------------------------------
package drow_pkg;

	// Sizing
	localparam int MAX_ITEMS   = 64;
	localparam int VALUE_RANGE = 1024;
	localparam int VALUE_W     = 64;
	localparam int RANK_W      = 7;

	localparam int ITEM_IDX_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
	localparam int STORE_IDX_W = $clog2(VALUE_RANGE);
	localparam int STORE_PTR_W = $clog2(VALUE_RANGE + 1);

	// Input item
	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      last_in;
	} item_t;

	// Result item
	typedef struct packed {
		logic [RANK_W-1:0] rank;
		logic              overflow;
		logic              last_out;
	} result_t;

	// Controller states
	typedef enum logic [2:0] {
		CS_LOAD,
		CS_CHECK,
		CS_MARK,
		CS_PREFIX,
		CS_EMIT_ITEM,
		CS_EMIT_RANK,
		CS_EMIT_OUT
	} ctrl_state_t;

	// Rank store sequencer states
	typedef enum logic [1:0] {
		SS_CLEAR,
		SS_IDLE,
		SS_PREFIX
	} store_state_t;

	// Commands from the controller to the rank store
	typedef struct packed {
		logic                   prefix_start;
		logic                   flip;
		logic                   mark_we;
		logic [STORE_IDX_W-1:0] mark_addr;
		logic                   look_re;
		logic [STORE_IDX_W-1:0] look_addr;
	} store_cmd_t;

endpackage

@@ src/drow_store.sv @@
// ----------------------------------------------------------------------------
// drow_store: presence and rank store
// One synchronous RAM of VALUE_RANGE entries. Each entry holds an epoch bit
// and a count. Entries whose epoch differs from the current one read as
// absent, so a finished set is retired by flipping the epoch. Runs the
// clearing sweep after reset and the prefix count sweep on command.
// ----------------------------------------------------------------------------
module drow_store import drow_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  store_cmd_t        cmd,
	output logic              busy,
	output logic [RANK_W-1:0] look_data
);

	store_state_t           state_q, state_d;
	logic [STORE_PTR_W-1:0] ptr_q;
	logic                   ep_q;
	logic [RANK_W-1:0]      acc_q;
	logic                   pf_v_s1;
	logic [STORE_IDX_W-1:0] pf_addr_s1;

	logic [RANK_W:0]        mem [VALUE_RANGE];
	logic [RANK_W:0]        rd_q;

	logic                   we;
	logic [STORE_IDX_W-1:0] waddr;
	logic [RANK_W:0]        wdata;
	logic                   re;
	logic [STORE_IDX_W-1:0] raddr;
	logic                   present;
	logic [RANK_W-1:0]      acc_next;
	logic                   ptr_end;
	logic                   clear_end;

	assign ptr_end   = (ptr_q == STORE_PTR_W'(VALUE_RANGE));
	assign clear_end = (ptr_q == STORE_PTR_W'(VALUE_RANGE - 1));
	assign present   = (rd_q[RANK_W] == ep_q);
	assign acc_next  = acc_q + RANK_W'(present);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			SS_CLEAR: begin
				if (clear_end) state_d = SS_IDLE;
			end
			SS_IDLE: begin
				if (cmd.prefix_start) state_d = SS_PREFIX;
			end
			SS_PREFIX: begin
				if (ptr_end) state_d = SS_IDLE;
			end
			default: state_d = SS_IDLE;
		endcase
	end

	// Memory port control
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		re    = 1'b0;
		raddr = '0;
		case (state_q)
			SS_CLEAR: begin
				we    = 1'b1;
				waddr = ptr_q[STORE_IDX_W-1:0];
				wdata = {~ep_q, {RANK_W{1'b0}}};
			end
			SS_IDLE: begin
				we    = cmd.mark_we;
				waddr = cmd.mark_addr;
				wdata = {ep_q, RANK_W'(1)};
				re    = cmd.look_re;
				raddr = cmd.look_addr;
			end
			SS_PREFIX: begin
				re    = !ptr_end;
				raddr = ptr_q[STORE_IDX_W-1:0];
			end
			default: begin
				we = 1'b0;
			end
		endcase
		// write back the running count in the cycle after the read
		if (pf_v_s1) begin
			we    = 1'b1;
			waddr = pf_addr_s1;
			wdata = {ep_q, acc_next};
		end
	end

	assign busy      = (state_q != SS_IDLE) || pf_v_s1;
	assign look_data = rd_q[RANK_W-1:0];

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SS_CLEAR;
			ptr_q   <= '0;
			ep_q    <= 1'b0;
			acc_q   <= '0;
			pf_v_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			pf_v_s1 <= (state_q == SS_PREFIX) && re;
			if (pf_v_s1) acc_q <= acc_next;
			if (cmd.flip) ep_q <= ~ep_q;
			case (state_q)
				SS_CLEAR: begin
					ptr_q <= clear_end ? '0 : ptr_q + 1'b1;
				end
				SS_IDLE: begin
					if (cmd.prefix_start) begin
						ptr_q <= '0;
						acc_q <= '0;
					end
				end
				SS_PREFIX: begin
					if (!ptr_end) ptr_q <= ptr_q + 1'b1;
				end
				default: ptr_q <= '0;
			endcase
		end
	end

	// Address of the pending write back
	always_ff @(posedge clk) begin
		pf_addr_s1 <= raddr;
	end

	// Store RAM with registered read
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rd_q <= mem[raddr];
	end

	// Read and write never hit the same entry in one cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		!(we && re && (waddr == raddr)))
		else $error("store read and write collide on one entry");

	// Marks arrive only while no sweep is running
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mark_we |-> ((state_q == SS_IDLE) && !pf_v_s1))
		else $error("mark write during a store sweep");

	// A prefix sweep starts only from an idle store
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.prefix_start |-> ((state_q == SS_IDLE) && !pf_v_s1))
		else $error("prefix start while the store is busy");

endmodule

@@ src/dense_rank_offset_window.sv @@
// ----------------------------------------------------------------------------
// dense_rank_offset_window: dense ranking by coordinate compression
// Collects a set of signed values, then emits each value's 1-based dense
// rank among the distinct values, in input order.
// ----------------------------------------------------------------------------
// Items of a set are taken one per cycle while the block loads; up to
// MAX_ITEMS are kept, later ones are dropped, and the item with last_in ends
// the set. Input then stalls while the set is ranked: a check of the spread,
// then marking (one item buffer read per item, then the last mark write and
// the hand-off), then the prefix count sweep over the whole rank store, then
// for each result an item read, a rank read and the output register load.
// When the spread is VALUE_RANGE or more, marking and the sweep are skipped
// and every result carries rank 0 with overflow set. After reset, a clearing
// pass runs through all VALUE_RANGE entries of the rank store before the
// first item is taken. The result register holds a finished result while
// the next set loads.
// ----------------------------------------------------------------------------
module dense_rank_offset_window import drow_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	ctrl_state_t               state_q, state_d;
	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          idx_q;
	logic signed [VALUE_W-1:0] min_q;
	logic signed [VALUE_W-1:0] max_q;
	logic                      ovf_q;
	logic                      mark_v_s1;
	logic                      result_valid_q;
	result_t                   result_q;

	logic [VALUE_W-1:0]        item_mem [MAX_ITEMS];
	logic [VALUE_W-1:0]        item_rd_q;

	store_cmd_t                cmd;
	logic                      store_busy;
	logic [RANK_W-1:0]         look_data;

	logic                      item_xfer;
	logic                      room;
	logic                      item_re;
	logic [VALUE_W-1:0]        offset;
	logic [VALUE_W-1:0]        spread;
	logic                      spread_ovf;
	logic                      mark_done;
	logic                      result_free;
	logic                      emit_last;
	logic                      emit_load;

	assign item_xfer   = item_valid && !item_stall;
	assign room        = (count_q < CNT_W'(MAX_ITEMS));
	assign offset      = item_rd_q - min_q;
	assign spread      = max_q - min_q;
	assign spread_ovf  = (spread >= VALUE_W'(VALUE_RANGE));
	assign mark_done   = (idx_q == count_q) && !mark_v_s1;
	assign result_free = !result_valid_q || !result_stall;
	assign emit_last   = (idx_q == (count_q - CNT_W'(1)));
	assign emit_load   = (state_q == CS_EMIT_OUT) && result_free;

	drow_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.busy      (store_busy),
		.look_data (look_data)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			CS_LOAD: begin
				if (item_xfer && item.last_in) state_d = CS_CHECK;
			end
			CS_CHECK: begin
				state_d = spread_ovf ? CS_EMIT_ITEM : CS_MARK;
			end
			CS_MARK: begin
				if (mark_done) state_d = CS_PREFIX;
			end
			CS_PREFIX: begin
				if (!store_busy) state_d = CS_EMIT_ITEM;
			end
			CS_EMIT_ITEM: begin
				state_d = CS_EMIT_RANK;
			end
			CS_EMIT_RANK: begin
				state_d = CS_EMIT_OUT;
			end
			CS_EMIT_OUT: begin
				if (result_free) state_d = emit_last ? CS_LOAD : CS_EMIT_ITEM;
			end
			default: state_d = CS_LOAD;
		endcase
	end

	// Handshake, buffer read and store commands
	always_comb begin
		item_stall       = (state_q != CS_LOAD) || store_busy;
		item_re          = ((state_q == CS_MARK) && (idx_q != count_q)) ||
		                   (state_q == CS_EMIT_ITEM);
		cmd.mark_we      = mark_v_s1;
		cmd.mark_addr    = offset[STORE_IDX_W-1:0];
		cmd.prefix_start = (state_q == CS_MARK) && mark_done;
		cmd.look_re      = (state_q == CS_EMIT_RANK) && !ovf_q;
		cmd.look_addr    = offset[STORE_IDX_W-1:0];
		cmd.flip         = emit_load && emit_last && !ovf_q;
	end

	// Item buffer with registered read
	always_ff @(posedge clk) begin
		if (item_xfer && room) item_mem[count_q[ITEM_IDX_W-1:0]] <= item.value;
		if (item_re) item_rd_q <= item_mem[idx_q[ITEM_IDX_W-1:0]];
	end

	// Set tracking and sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= CS_LOAD;
			count_q   <= '0;
			idx_q     <= '0;
			min_q     <= {1'b0, {(VALUE_W-1){1'b1}}};
			max_q     <= {1'b1, {(VALUE_W-1){1'b0}}};
			ovf_q     <= 1'b0;
			mark_v_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			mark_v_s1 <= (state_q == CS_MARK) && item_re;
			case (state_q)
				CS_LOAD: begin
					// keep the item and widen the window unless the buffer is full
					if (item_xfer && room) begin
						count_q <= count_q + 1'b1;
						if (item.value < min_q) min_q <= item.value;
						if (item.value > max_q) max_q <= item.value;
					end
				end
				CS_CHECK: begin
					ovf_q <= spread_ovf;
					idx_q <= '0;
				end
				CS_MARK: begin
					if (item_re) idx_q <= idx_q + 1'b1;
					else if (mark_done) idx_q <= '0;
				end
				CS_EMIT_OUT: begin
					if (result_free) begin
						// retire the set after its final result
						if (emit_last) begin
							count_q <= '0;
							idx_q   <= '0;
							min_q   <= {1'b0, {(VALUE_W-1){1'b1}}};
							max_q   <= {1'b1, {(VALUE_W-1){1'b0}}};
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: begin
					idx_q <= idx_q;
				end
			endcase
		end
	end

	// Result register: load when free, drop valid after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (emit_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			result_q.rank     <= ovf_q ? '0 : look_data;
			result_q.overflow <= ovf_q;
			result_q.last_out <= emit_last;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Buffer fill never passes its depth
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ITEMS))
		else $error("item count beyond buffer depth");

	// Overflowed results carry rank zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.overflow) |-> (result.rank == '0))
		else $error("overflow result with nonzero rank");

	// A nonempty set keeps a window with minimum not above maximum
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> (min_q <= max_q))
		else $error("window minimum above maximum");

	// Marking and lookups only run against an idle store
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == CS_MARK) || (state_q == CS_EMIT_RANK)) |-> !store_busy)
		else $error("store access while a sweep runs");

endmodule
